@@ src/lzssd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the LZSS stream decoder.
// No dependencies; used by lzss_stream_decoder_top.
package lzssd_pkg;

    localparam int BYTE_W     = 8;
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int LEN_W      = 4;
    localparam int FLAGS_W    = 4;
    localparam logic [FLAGS_W-1:0] FLAGS_PER_BYTE = 4'd8;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [HIST_AW-1:0] hist_addr_t;

endpackage

@@ src/lzss_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// LZSS stream decoder, 12-bit offset and 4-bit length, with 4096-byte history.
// Depends on lzssd_pkg and lzssd_ram.
//
// Usage:
//   s_axis carries compressed bytes, one per item, in s_axis_tdata[7:0].
//   m_axis carries decoded bytes in m_axis_tdata; m_axis_tlast marks the last
//   byte caused by one input item and m_axis_tuser marks the end-of-stream
//   item, whose data is zero.
//   Flag bytes and first match bytes give no output.
//   A literal or end marker gives one item from the output register in the next cycle.
//   A copy of n bytes (2 to 16) moves each byte by a history read (ST_RD)
//   and then a write-and-output step (ST_WR) on the single history RAM.
//   Input is taken only while no copy is running and the output register is
//   free or being emptied; a stall on m_axis holds the copy where it is.
//   After an end marker the parser and write pointer return to zero; the
//   history keeps its contents.
//   Reset clears the parser, the write pointer and the output valid; the
//   history is not cleared and needs no clearing pass.
module lzss_stream_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] end_of_stream
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;

    logic [1:0]                        state_reg, state_next;
    lzssd_pkg::hist_addr_t             wp_reg, wp_next;
    lzssd_pkg::hist_addr_t             src_reg, src_next;
    logic [lzssd_pkg::LEN_W-1:0]       cnt_reg, cnt_next;
    lzssd_pkg::byte_t                  flag_bits_reg, flag_bits_next;
    logic [lzssd_pkg::FLAGS_W-1:0]     flags_left_reg, flags_left_next;
    logic                              phase_reg, phase_next;
    lzssd_pkg::byte_t                  first_reg, first_next;

    logic                              out_valid_reg, out_valid_next;
    lzssd_pkg::byte_t                  out_byte_reg, out_byte_next;
    logic                              out_last_reg, out_last_next;
    logic                              out_end_reg, out_end_next;

    logic                              out_free;
    logic                              in_acc;
    logic                              ram_we;
    lzssd_pkg::byte_t                  ram_wdata;
    logic                              ram_re;
    lzssd_pkg::byte_t                  ram_rdata;
    lzssd_pkg::hist_addr_t             offset;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign offset        = {first_reg, s_axis_tdata[7:4]};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_end_reg;

    lzssd_ram #(
        .WIDTH (lzssd_pkg::BYTE_W),
        .DEPTH (lzssd_pkg::HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        src_next        = src_reg;
        cnt_next        = cnt_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        phase_next      = phase_reg;
        first_next      = first_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;
        ram_we          = 1'b0;
        ram_wdata       = s_axis_tdata;
        ram_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    phase_next = 1'b0;
                    if (phase_reg)
                    begin
                        if (s_axis_tdata[3:0] == '0)
                        begin
                            // end marker
                            out_valid_next  = 1'b1;
                            out_byte_next   = '0;
                            out_last_next   = 1'b1;
                            out_end_next    = 1'b1;
                            flag_bits_next  = '0;
                            flags_left_next = '0;
                            first_next      = '0;
                            wp_next         = '0;
                        end
                        else
                        begin
                            src_next   = wp_reg - offset - 1'b1;
                            cnt_next   = s_axis_tdata[3:0];
                            state_next = ST_RD;
                        end
                    end
                    else if (flags_left_reg == '0)
                    begin
                        flag_bits_next  = s_axis_tdata;
                        flags_left_next = lzssd_pkg::FLAGS_PER_BYTE;
                    end
                    else if (flag_bits_reg[0])
                    begin
                        first_next = s_axis_tdata;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        wp_next         = wp_reg + 1'b1;
                        out_valid_next  = 1'b1;
                        out_byte_next   = s_axis_tdata;
                        out_last_next   = 1'b1;
                        out_end_next    = 1'b0;
                        flag_bits_next  = flag_bits_reg >> 1;
                        flags_left_next = flags_left_reg - 1'b1;
                    end
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = ram_rdata;
                    wp_next        = wp_reg + 1'b1;
                    src_next       = src_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_last_next  = (cnt_reg == '0);
                    out_end_next   = 1'b0;
                    if (cnt_reg == '0)
                    begin
                        state_next      = ST_IDLE;
                        flag_bits_next  = flag_bits_reg >> 1;
                        flags_left_next = flags_left_reg - 1'b1;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            cnt_reg        <= '0;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            phase_reg      <= 1'b0;
            first_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            cnt_reg        <= cnt_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            phase_reg      <= phase_next;
            first_reg      <= first_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

endmodule

@@ src/lzssd_ram.sv @@
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
